/* hdl/mcr_pkg.sv */
// Package for the midpoint circle rasterizer: widths, function codes and
// the types shared by the sequencer and the decision unit. No dependencies.
`timescale 1ns / 1ps

package mcr_pkg;

   localparam int COORD_BITS  = 12;
   localparam int RADIUS_BITS = 10;

   localparam int POINT_BITS  = COORD_BITS + 1;
   localparam int OFFSET_BITS = RADIUS_BITS + 1;
   localparam int TERM_BITS   = RADIUS_BITS + 2;
   localparam int ERR_BITS    = RADIUS_BITS + 3;
   localparam int DIAM_BITS   = RADIUS_BITS + 1;
   localparam int INDEX_BITS  = 3;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   localparam logic [INDEX_BITS-1:0] LAST_INDEX = {INDEX_BITS{1'b1}};

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                   start;
      logic                   step;
      logic [RADIUS_BITS-1:0] radius;
   } dec_ctrl_type;

   typedef struct packed {
      logic                          drawing;
      logic                          crossed;
      logic                          done_next;
      logic signed [OFFSET_BITS-1:0] offset_x;
      logic signed [OFFSET_BITS-1:0] offset_y;
   } dec_status_type;

endpackage

/* hdl/mcr_decision.sv */
// Midpoint decision unit: offsets, step terms, error and drawing flag.
// Depends on mcr_pkg.
`timescale 1ns / 1ps

module mcr_decision
   import mcr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  dec_ctrl_type   ctrl,
   output dec_status_type status
);

   localparam int WIDE = ERR_BITS + 1;

   logic signed [OFFSET_BITS-1:0] offset_x_ff, offset_x_in;
   logic signed [OFFSET_BITS-1:0] offset_y_ff, offset_y_in;
   logic signed [TERM_BITS-1:0]   term_x_ff, term_x_in;
   logic signed [TERM_BITS-1:0]   term_y_ff, term_y_in;
   logic signed [ERR_BITS-1:0]    error_ff, error_in;
   logic [DIAM_BITS-1:0]          diam_ff, diam_in;
   logic                          drawing_ff, drawing_in;

   logic signed [WIDE-1:0]        err_a, err_b, err_c, diam_wide;
   logic signed [OFFSET_BITS-1:0] ox_next, oy_next;
   logic signed [TERM_BITS-1:0]   tx_next, ty_next;
   logic signed [ERR_BITS-1:0]    err_next;
   logic [DIAM_BITS-1:0]          diam_start;

   always_comb begin
      err_a     = WIDE'(error_ff);
      diam_wide = $signed(WIDE'(diam_ff));
      oy_next   = offset_y_ff;
      ty_next   = term_y_ff;
      err_b     = err_a;
      if (err_a <= 0) begin
         oy_next = offset_y_ff + OFFSET_BITS'(1);
         err_b   = err_a + WIDE'(term_y_ff);
         ty_next = term_y_ff + TERM_BITS'(2);
      end
      ox_next = offset_x_ff;
      tx_next = term_x_ff;
      err_c   = err_b;
      if (err_b > 0) begin
         ox_next = offset_x_ff - OFFSET_BITS'(1);
         tx_next = term_x_ff + TERM_BITS'(2);
         err_c   = err_b + WIDE'(tx_next) - diam_wide;
      end
      err_next = err_c[ERR_BITS-1:0];
   end

   assign diam_start = {ctrl.radius, 1'b0};

   always_comb begin
      offset_x_in = offset_x_ff;
      offset_y_in = offset_y_ff;
      term_x_in   = term_x_ff;
      term_y_in   = term_y_ff;
      error_in    = error_ff;
      diam_in     = diam_ff;
      drawing_in  = drawing_ff;
      if (ctrl.start) begin
         offset_x_in = $signed({1'b0, ctrl.radius}) - OFFSET_BITS'(1);
         offset_y_in = '0;
         term_x_in   = TERM_BITS'(1);
         term_y_in   = TERM_BITS'(1);
         diam_in     = diam_start;
         error_in    = ERR_BITS'(1) - ERR_BITS'(diam_start);
         drawing_in  = 1'b1;
      end else if (ctrl.step && drawing_ff) begin
         if (status.crossed) begin
            drawing_in = 1'b0;
         end else begin
            offset_x_in = ox_next;
            offset_y_in = oy_next;
            term_x_in   = tx_next;
            term_y_in   = ty_next;
            error_in    = err_next;
            drawing_in  = !status.done_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         term_x_ff   <= TERM_BITS'(1);
         term_y_ff   <= TERM_BITS'(1);
         error_ff    <= '0;
         diam_ff     <= '0;
         drawing_ff  <= 1'b0;
      end else begin
         offset_x_ff <= offset_x_in;
         offset_y_ff <= offset_y_in;
         term_x_ff   <= term_x_in;
         term_y_ff   <= term_y_in;
         error_ff    <= error_in;
         diam_ff     <= diam_in;
         drawing_ff  <= drawing_in;
      end
   end

   assign status.drawing   = drawing_ff;
   assign status.crossed   = offset_x_ff < offset_y_ff;
   assign status.done_next = ox_next < oy_next;
   assign status.offset_x  = offset_x_ff;
   assign status.offset_y  = offset_y_ff;

endmodule

/* hdl/mcr_point_unit.sv */
// Shared point adder: mirrors the held offsets into one octant per cycle while the output is not stalled.
// Depends on mcr_pkg.
`timescale 1ns / 1ps

module mcr_point_unit
   import mcr_pkg::*;
(
   input  logic signed [COORD_BITS-1:0]  center_x,
   input  logic signed [COORD_BITS-1:0]  center_y,
   input  logic signed [OFFSET_BITS-1:0] offset_x,
   input  logic signed [OFFSET_BITS-1:0] offset_y,
   input  logic [INDEX_BITS-1:0]         index,
   output logic signed [POINT_BITS-1:0]  point_x,
   output logic signed [POINT_BITS-1:0]  point_y
);

   localparam int SUM_BITS = ((POINT_BITS > OFFSET_BITS) ? POINT_BITS : OFFSET_BITS) + 1;

   logic signed [OFFSET_BITS-1:0] delta_x, delta_y;
   logic signed [SUM_BITS-1:0]    sum_x, sum_y;

   // Octants four to seven swap the roles of the two offsets.
   always_comb begin
      delta_x = index[2] ? offset_y : offset_x;
      delta_y = index[2] ? offset_x : offset_y;
      if (index[1]) begin
         sum_x = SUM_BITS'(center_x) - SUM_BITS'(delta_x);
      end else begin
         sum_x = SUM_BITS'(center_x) + SUM_BITS'(delta_x);
      end
      if (index[0]) begin
         sum_y = SUM_BITS'(center_y) + SUM_BITS'(delta_y);
      end else begin
         sum_y = SUM_BITS'(center_y) - SUM_BITS'(delta_y);
      end
   end

   assign point_x = sum_x[POINT_BITS-1:0];
   assign point_y = sum_y[POINT_BITS-1:0];

endmodule

/* hdl/midpoint_circle_rasterizer_unit.sv */
// Midpoint circle rasterizer top level: request sequencer and output register.
// Depends on mcr_pkg, mcr_decision and mcr_point_unit.
// A start word emits nothing. A step word that finds the circle drawing and not crossed
// holds the request side while the decision terms update and the emit state then loads
// eight points, one per octant, into the output register, each load waiting out a stall.
// Synchronous active-high reset clears the sequencer and an idle circle.
`timescale 1ns / 1ps

module midpoint_circle_rasterizer_unit
   import mcr_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic signed [COORD_BITS-1:0] req_center_x,
   input  logic signed [COORD_BITS-1:0] req_center_y,
   input  logic [RADIUS_BITS-1:0]       req_radius,
   input  logic [3:0]                   req_pen_color,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [POINT_BITS-1:0] rsp_point_x,
   output logic signed [POINT_BITS-1:0] rsp_point_y,
   output logic [3:0]                   rsp_point_color,
   output logic                         rsp_last_of_step,
   output logic                         rsp_circle_done
);

   state_type state_ff, state_in;
   logic [INDEX_BITS-1:0]         index_ff, index_in;
   logic signed [COORD_BITS-1:0]  center_x_ff, center_y_ff;
   logic [3:0]                    color_ff;
   logic signed [OFFSET_BITS-1:0] snap_x_ff, snap_y_ff;
   logic                          done_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [POINT_BITS-1:0]  rsp_x_ff, rsp_y_ff;
   logic [3:0]                    rsp_color_ff;
   logic                          rsp_last_ff, rsp_done_ff;

   logic                          req_accept, go_emit, load;
   logic signed [POINT_BITS-1:0]  point_x, point_y;
   dec_ctrl_type                  ctrl;
   dec_status_type                status;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      ctrl.start  = req_accept && (req_func == FUNC_START);
      ctrl.step   = req_accept && (req_func == FUNC_STEP);
      ctrl.radius = req_radius;
   end

   assign go_emit = ctrl.step && status.drawing && !status.crossed;
   assign load    = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   mcr_decision u_decision (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .status (status)
   );

   mcr_point_unit u_point (
      .center_x (center_x_ff),
      .center_y (center_y_ff),
      .offset_x (snap_x_ff),
      .offset_y (snap_y_ff),
      .index    (index_ff),
      .point_x  (point_x),
      .point_y  (point_y)
   );

   always_comb begin
      state_in     = state_ff;
      index_in     = index_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            index_in = '0;
            if (go_emit) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               index_in     = index_ff + INDEX_BITS'(1);
               if (index_ff == LAST_INDEX) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         index_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         center_x_ff  <= '0;
         center_y_ff  <= '0;
         color_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ctrl.start) begin
            center_x_ff <= req_center_x;
            center_y_ff <= req_center_y;
            color_ff    <= req_pen_color;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go_emit) begin
         snap_x_ff <= status.offset_x;
         snap_y_ff <= status.offset_y;
         done_ff   <= status.done_next;
      end
      if (load) begin
         rsp_x_ff     <= point_x;
         rsp_y_ff     <= point_y;
         rsp_color_ff <= color_ff;
         rsp_last_ff  <= (index_ff == LAST_INDEX);
         rsp_done_ff  <= done_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_point_x      = rsp_x_ff;
   assign rsp_point_y      = rsp_y_ff;
   assign rsp_point_color  = rsp_color_ff;
   assign rsp_last_of_step = rsp_last_ff;
   assign rsp_circle_done  = rsp_done_ff;

`ifndef SYNTHESIS
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> req_stall)
      else $error("request taken while points are being emitted");

   a_enter_emit: assert property (@(posedge clock) disable iff (reset)
      go_emit |=> (state_ff == ST_EMIT) && (index_ff == '0))
      else $error("step did not start emission at the first octant");

   a_last_returns: assert property (@(posedge clock) disable iff (reset)
      (load && (index_ff == LAST_INDEX)) |=> (state_ff == ST_IDLE) && rsp_last_of_step)
      else $error("eighth point did not end the step");

   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("stalled output word dropped");
`endif

endmodule
